// File: rtl/core/grp_pkg.sv
// ----------------------------------------------------------------------------
// grp_pkg: shared types and constants of the growing rectangle packer
// Defaults for the top-level parameters and the status and state codes.
// ----------------------------------------------------------------------------
`default_nettype none
package grp_pkg;
  localparam int unsigned MAX_RECTS_DEF   = 64;
  localparam int unsigned MAX_SIDE_DEF    = 4096;
  localparam int unsigned SAMPLE_STEP_DEF = 32;

  localparam logic [1:0] ST_PLACED = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_LIMIT  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_GROW, S_MIN_RD, S_MIN_ACC, S_ROW, S_COL, S_PT, S_CMP, S_ADV, S_DONE
  } state_t;
endpackage
`default_nettype wire

// File: rtl/core/growing_rectangle_packer_top.sv
// ----------------------------------------------------------------------------
// growing_rectangle_packer_top: first-fit packer into a growing box
// Sequencer over a rectangle memory: grid scan, sample test, box growth.
// ----------------------------------------------------------------------------
// channel  ports                                   transfer
// input    in_item_width, in_item_height           start & !busy
// result   out_place_x/_y, out_box_*, out_status   out_valid, one cycle
//
// How long an item takes depends on the single read port of the rectangle
// memory: the step-size pass walks all placed rectangles one read at a time,
// and each sample point tested walks them until the first cover; growth
// steps, grid rows, corners, the commit and the result strobe each take a
// state. With a full store the result strobe comes in the cycle after the
// transfer. busy is high from the transfer until the result strobe; results
// cannot be held off, so nothing stalls the block. Reset is synchronous and
// clears count and box; memory entries are used only below the count.
`default_nettype none
module growing_rectangle_packer_top #(
  parameter int unsigned MAX_RECTS   = grp_pkg::MAX_RECTS_DEF,
  parameter int unsigned MAX_SIDE    = grp_pkg::MAX_SIDE_DEF,
  parameter int unsigned SAMPLE_STEP = grp_pkg::SAMPLE_STEP_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [12:0] in_item_width,
  input  wire logic [12:0] in_item_height,
  output logic             out_valid,
  output logic [11:0]      out_place_x,
  output logic [11:0]      out_place_y,
  output logic [12:0]      out_box_width,
  output logic [12:0]      out_box_height,
  output logic [1:0]       out_status
);
  import grp_pkg::*;
  localparam int unsigned AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int unsigned CW = $clog2(MAX_RECTS + 1);
  localparam int unsigned SW = 16; // coordinate width, holds sums up to 2*MAX_SIDE
  localparam int unsigned DW = 4 * SW;
  localparam logic [SW-1:0] SIDE_MAX = SW'(MAX_SIDE);
  localparam logic [SW-1:0] SSTEP = SW'(SAMPLE_STEP);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_RECTS);

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] box_w_r, box_w_nxt, box_h_r, box_h_nxt;
  logic [SW-1:0] bw_r, bw_nxt, bh_r, bh_nxt, iw_r, iw_nxt, ih_r, ih_nxt;
  logic [SW-1:0] stw_r, stw_nxt, sth_r, sth_nxt;
  logic [SW-1:0] cx_r, cx_nxt, cy_r, cy_nxt, sx_r, sx_nxt, sy_r, sy_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          hit_r, hit_nxt;
  logic [1:0]    stat_r, stat_nxt;
  logic [11:0]   px_r, px_nxt, py_r, py_nxt;

  logic          we;
  logic [AW-1:0] raddr;
  logic [DW-1:0] wdata, rdata;
  logic [SW-1:0] rx, ry, rw, rh, nw, nh;
  logic          rd_ok, cov;

  grp_store #(.DEPTH(MAX_RECTS), .AW(AW), .DW(DW)) u_store (
    .clk(clk), .we(we), .waddr(cnt_r[AW-1:0]), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign {rx, ry, rw, rh} = rdata;
  assign wdata = {4'(0), px_r, 4'(0), py_r, iw_r, ih_r};
  assign raddr = idx_r[AW-1:0];
  // entry read last cycle is valid when its index is below the count
  assign rd_ok = (idx_r != 0) && (idx_r <= cnt_r);
  assign cov = (rx <= sx_r) && (rx + rw > sx_r) && (ry <= sy_r) && (ry + rh > sy_r);

  // growth choice for the current box
  always_comb begin
    nw = bw_r;
    nh = bh_r;
    if (iw_r > bw_r && ih_r > bh_r) begin
      nw = bw_r + iw_r;
      nh = bh_r + ih_r;
    end else if (iw_r > bw_r) begin
      nw = bw_r + iw_r;
    end else if (ih_r > bh_r) begin
      nh = bh_r + ih_r;
    end else if (bw_r < bh_r) begin
      nw = bw_r + iw_r;
    end else begin
      nh = bh_r + ih_r;
    end
  end

  // sequencer next state and datapath
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r; box_w_nxt = box_w_r; box_h_nxt = box_h_r;
    bw_nxt = bw_r; bh_nxt = bh_r; iw_nxt = iw_r; ih_nxt = ih_r;
    stw_nxt = stw_r; sth_nxt = sth_r; cx_nxt = cx_r; cy_nxt = cy_r;
    sx_nxt = sx_r; sy_nxt = sy_r; idx_nxt = idx_r; hit_nxt = hit_r;
    stat_nxt = stat_r; px_nxt = px_r; py_nxt = py_r;
    we = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          iw_nxt = (in_item_width == 0) ? SW'(1) : SW'(in_item_width);
          ih_nxt = (in_item_height == 0) ? SW'(1) : SW'(in_item_height);
          bw_nxt = box_w_r;
          bh_nxt = box_h_r;
          px_nxt = '0;
          py_nxt = '0;
          stat_nxt = ST_PLACED;
          state_nxt = (cnt_r >= CNT_MAX) ? S_DONE : S_GROW;
          if (cnt_r >= CNT_MAX) stat_nxt = ST_FULL;
        end
      end
      S_GROW: begin
        // fits: scan; does not fit: grow first, or stop at the side limit
        if (iw_r <= bw_r && ih_r <= bh_r) begin
          stw_nxt = iw_r;
          sth_nxt = ih_r;
          idx_nxt = '0;
          state_nxt = S_MIN_RD;
        end else if (nw > SIDE_MAX || nh > SIDE_MAX) begin
          stat_nxt = ST_LIMIT;
          state_nxt = S_DONE;
        end else begin
          bw_nxt = nw;
          bh_nxt = nh;
        end
      end
      S_MIN_RD: begin
        // walk entries for the smallest width and height
        if (rd_ok) begin
          if (rw < stw_r) stw_nxt = rw;
          if (rh < sth_r) sth_nxt = rh;
        end
        if (idx_r > cnt_r) begin
          cy_nxt = '0;
          state_nxt = S_ROW;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_ROW: begin
        if (cy_r >= bh_r || cy_r + ih_r > bh_r) begin
          state_nxt = S_ADV;
        end else begin
          cx_nxt = '0;
          state_nxt = S_COL;
        end
      end
      S_COL: begin
        if (cx_r >= bw_r || cx_r + iw_r > bw_r) begin
          cy_nxt = cy_r + sth_r;
          state_nxt = S_ROW;
        end else begin
          sx_nxt = cx_r;
          sy_nxt = cy_r;
          state_nxt = S_PT;
        end
      end
      S_PT: begin
        // start a memory walk for one sample point
        idx_nxt = '0;
        hit_nxt = 1'b0;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (rd_ok && cov) hit_nxt = 1'b1;
        if (idx_r > cnt_r || (rd_ok && cov)) begin
          if (hit_r || (rd_ok && cov)) begin
            cx_nxt = cx_r + stw_r;
            state_nxt = S_COL;
          end else if (sx_r + SSTEP < cx_r + iw_r) begin
            sx_nxt = sx_r + SSTEP;
            state_nxt = S_PT;
          end else if (sy_r + SSTEP < cy_r + ih_r) begin
            sx_nxt = cx_r;
            sy_nxt = sy_r + SSTEP;
            state_nxt = S_PT;
          end else begin
            px_nxt = cx_r[11:0];
            py_nxt = cy_r[11:0];
            state_nxt = S_MIN_ACC;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_MIN_ACC: begin
        // commit placement
        we = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        box_w_nxt = bw_r;
        box_h_nxt = bh_r;
        state_nxt = S_DONE;
      end
      S_ADV: begin
        // scan failed: grow and retry, or stop at the side limit
        if (nw > SIDE_MAX || nh > SIDE_MAX) begin
          stat_nxt = ST_LIMIT;
          state_nxt = S_DONE;
        end else begin
          bw_nxt = nw;
          bh_nxt = nh;
          state_nxt = S_GROW;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      box_w_r <= '0;
      box_h_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      box_w_r <= box_w_nxt;
      box_h_r <= box_h_nxt;
    end
    bw_r <= bw_nxt; bh_r <= bh_nxt; iw_r <= iw_nxt; ih_r <= ih_nxt;
    stw_r <= stw_nxt; sth_r <= sth_nxt; cx_r <= cx_nxt; cy_r <= cy_nxt;
    sx_r <= sx_nxt; sy_r <= sy_nxt; idx_r <= idx_nxt; hit_r <= hit_nxt;
    stat_r <= stat_nxt; px_r <= px_nxt; py_r <= py_nxt;
  end

  // outputs
  always_comb begin
    busy = (state_r != S_IDLE);
    out_valid = (state_r == S_DONE);
    out_place_x = px_r;
    out_place_y = py_r;
    out_box_width = box_w_r[12:0];
    out_box_height = box_h_r[12:0];
    out_status = stat_r;
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CNT_MAX)
    else $error("count above depth");
  a_box: assert property (@(posedge clk) disable iff (!rst_n)
    box_w_r <= SIDE_MAX && box_h_r <= SIDE_MAX) else $error("box above limit");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double strobe");
  a_we: assert property (@(posedge clk) disable iff (!rst_n)
    we |=> out_valid && out_status == ST_PLACED) else $error("write without result");
endmodule
`default_nettype wire

// File: rtl/core/grp_store.sv
// ----------------------------------------------------------------------------
// grp_store: placed rectangle memory
// One write port and one registered read port; read data follows the address in the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module grp_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned DW    = 56
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: tb/tb_growing_rectangle_packer_top.sv
// ----------------------------------------------------------------------------
// tb_growing_rectangle_packer_top: self-checking bench of the rectangle packer
// Items are sent one at a time, some after a random gap. A scoreboard keeps its own
// box and rectangle store, predicts each placement, and checks every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_growing_rectangle_packer_top;
  import grp_pkg::*;

  localparam int unsigned EFFORT_CAP = 30000;
  localparam int unsigned STALL_LIMIT = 1000000;
  localparam int N_RANDOM = 125;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [12:0] bw;
    logic [12:0] bh;
    logic [1:0]  status;
  } placement_t;

  // placement predictor with a queue of expected results
  class packer_scoreboard;
    int unsigned rx[grp_pkg::MAX_RECTS_DEF];
    int unsigned ry[grp_pkg::MAX_RECTS_DEF];
    int unsigned rw[grp_pkg::MAX_RECTS_DEF];
    int unsigned rh[grp_pkg::MAX_RECTS_DEF];
    int unsigned n_rects = 0;
    int unsigned box_w = 0;
    int unsigned box_h = 0;
    placement_t pending[$];
    int errors = 0;
    int n_placed = 0;
    int n_full = 0;
    int n_limit = 0;

    // runs one insertion; updates the state only when commit is set.
    // work is a rough cycle estimate; a nonzero cap stops the search early
    function automatic void place(input int unsigned w_in, input int unsigned h_in,
                                  input bit commit, input int unsigned cap,
                                  output placement_t r, output int unsigned work);
      int unsigned iw, ih, bw, bh, nw, nh, sw, sh, cx, cy, sx, sy, px, py;
      bit found, hit, blocked;
      iw = (w_in == 0) ? 1 : w_in;
      ih = (h_in == 0) ? 1 : h_in;
      bw = box_w;
      bh = box_h;
      px = 0;
      py = 0;
      work = 0;
      r.status = grp_pkg::ST_PLACED;
      if (n_rects >= grp_pkg::MAX_RECTS_DEF) begin
        r.status = grp_pkg::ST_FULL;
      end else begin
        forever begin
          nw = bw;
          nh = bh;
          found = 0;
          work += 2 * n_rects + 4;
          if (iw > bw && ih > bh) begin
            nw = bw + iw;
            nh = bh + ih;
          end else if (iw > bw) begin
            nw = bw + iw;
          end else if (ih > bh) begin
            nh = bh + ih;
          end else begin
            // first-fit grid scan, row by row
            sw = iw;
            sh = ih;
            for (int i = 0; i < n_rects; i++) begin
              if (rw[i] < sw) sw = rw[i];
              if (rh[i] < sh) sh = rh[i];
            end
            for (cy = 0; cy < bh && !found; cy += sh) begin
              if (cy + ih > bh) break;
              for (cx = 0; cx < bw && !found; cx += sw) begin
                if (cx + iw > bw) break;
                if (cap != 0 && work > cap) return;
                work += 2;
                blocked = 0;
                for (sy = cy; sy < cy + ih && !blocked;
                     sy += grp_pkg::SAMPLE_STEP_DEF)
                  for (sx = cx; sx < cx + iw && !blocked;
                       sx += grp_pkg::SAMPLE_STEP_DEF) begin
                    work += n_rects + 3;
                    hit = 0;
                    for (int i = 0; i < n_rects && !hit; i++)
                      hit = rx[i] <= sx && rx[i] + rw[i] > sx &&
                            ry[i] <= sy && ry[i] + rh[i] > sy;
                    blocked = hit;
                  end
                if (!blocked) begin
                  found = 1;
                  px = cx;
                  py = cy;
                end
              end
            end
            if (!found) begin
              if (bw < bh) nw = bw + iw;
              else nh = bh + ih;
            end
          end
          if (found) break;
          if (nw > grp_pkg::MAX_SIDE_DEF || nh > grp_pkg::MAX_SIDE_DEF) begin
            r.status = grp_pkg::ST_LIMIT;
            px = 0;
            py = 0;
            break;
          end
          bw = nw;
          bh = nh;
        end
        if (r.status == grp_pkg::ST_PLACED && commit) begin
          rx[n_rects] = px;
          ry[n_rects] = py;
          rw[n_rects] = iw;
          rh[n_rects] = ih;
          n_rects++;
          box_w = bw;
          box_h = bh;
        end
      end
      r.x = px[11:0];
      r.y = py[11:0];
      r.bw = (r.status == grp_pkg::ST_PLACED && commit) ? bw[12:0] : box_w[12:0];
      r.bh = (r.status == grp_pkg::ST_PLACED && commit) ? bh[12:0] : box_h[12:0];
    endfunction

    // estimated cycles for an item, stopping past cap
    function automatic int unsigned effort(int unsigned w, int unsigned h,
                                           int unsigned cap);
      placement_t r;
      int unsigned work;
      place(w, h, 0, cap, r, work);
      if (work > cap) work = cap + 1;
      return work;
    endfunction

    // input transfer: predict and queue the result
    function automatic void note_item(int unsigned w, int unsigned h);
      placement_t r;
      int unsigned work;
      place(w, h, 1, 0, r, work);
      case (r.status)
        grp_pkg::ST_PLACED: n_placed++;
        grp_pkg::ST_FULL:   n_full++;
        default:            n_limit++;
      endcase
      pending = {pending, r};
    endfunction

    // result transfer: compare with the oldest prediction
    function automatic void check_result(placement_t got);
      placement_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result x=%0d y=%0d box=%0dx%0d status=%0d",
                   got.x, got.y, got.bw, got.bh, got.status);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display({"result differs: expected x=%0d y=%0d box=%0dx%0d status=%0d,",
                    " got x=%0d y=%0d box=%0dx%0d status=%0d"},
                   want.x, want.y, want.bw, want.bh, want.status,
                   got.x, got.y, got.bw, got.bh, got.status);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [12:0] in_item_width = '0;
  logic [12:0] in_item_height = '0;
  logic        out_valid;
  logic [11:0] out_place_x;
  logic [11:0] out_place_y;
  logic [12:0] out_box_width;
  logic [12:0] out_box_height;
  logic [1:0]  out_status;

  packer_scoreboard sb = new();
  bit allow_gaps = 1;
  int stall_cycles = 0;

  growing_rectangle_packer_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item_width(in_item_width), .in_item_height(in_item_height),
    .out_valid(out_valid), .out_place_x(out_place_x), .out_place_y(out_place_y),
    .out_box_width(out_box_width), .out_box_height(out_box_height),
    .out_status(out_status)
  );

  always #2 clk = ~clk;

  // result monitor
  always @(posedge clk) begin
    placement_t got;
    if (rst_n && out_valid) begin
      got.x = out_place_x;
      got.y = out_place_y;
      got.bw = out_box_width;
      got.bh = out_box_height;
      got.status = out_status;
      sb.check_result(got);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("growing_rectangle_packer_top: mismatch");
        $finish;
      end
    end
  end

  // one item: optional gap, then hold start until the transfer
  task automatic send_item(int unsigned w, int unsigned h);
    int gap;
    gap = (allow_gaps && $urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
    repeat (gap) begin
      @(negedge clk);
      start <= 0;
    end
    @(negedge clk);
    start <= 1;
    in_item_width <= w[12:0];
    in_item_height <= h[12:0];
    do @(posedge clk); while (busy);
    sb.note_item(w, h);
  endtask

  // random size with a bias toward moderate rectangles
  function automatic int unsigned pick_side();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return $urandom_range(1, 31);
      2:       return $urandom_range(1000, 4096);
      3:       return $urandom_range(4097, 8191);
      default: return $urandom_range(32, 600);
    endcase
  endfunction

  initial begin
    int unsigned w, h;
    int tries;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: limits, zero sizes, all-ones fields, each growth rule
    send_item(0, 8191);
    send_item(8191, 0);
    send_item(8191, 8191);
    send_item(4097, 1);
    send_item(1, 4097);
    send_item(64, 64);
    send_item(200, 64);
    send_item(64, 300);
    send_item(64, 64);
    send_item(128, 96);
    send_item(4096, 64);
    send_item(64, 4096);
    send_item(96, 96);

    // hold off until the block has drained
    @(negedge clk);
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);

    // random items, each kept within EFFORT_CAP of estimated work
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == N_RANDOM - 20) allow_gaps = 0;
      tries = 0;
      do begin
        w = pick_side();
        h = pick_side();
        tries++;
      end while (sb.effort(w, h, EFFORT_CAP) > EFFORT_CAP && tries < 40);
      if (tries >= 40) begin
        w = 8191;
        h = $urandom_range(0, 8191);
      end
      send_item(w, h);
    end
    @(negedge clk);
    start <= 0;

    // drain
    tries = 0;
    while (sb.pending.size() != 0 && tries < STALL_LIMIT) begin
      @(posedge clk);
      tries++;
    end
    repeat (20) @(posedge clk);

    $display("covered %0d placed, %0d store-full and %0d side-limit items",
             sb.n_placed, sb.n_full, sb.n_limit);
    $display("final box %0dx%0d holding %0d rectangles", sb.box_w, sb.box_h, sb.n_rects);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("growing_rectangle_packer_top: match");
    end else begin
      $display("growing_rectangle_packer_top: mismatch");
    end
    $finish;
  end
endmodule

`default_nettype wire

// File: growing_rectangle_packer_top.f
rtl/core/grp_pkg.sv
rtl/core/grp_store.sv
rtl/core/growing_rectangle_packer_top.sv
tb/tb_growing_rectangle_packer_top.sv
